@@ hw/rtl/lfid_pkg.sv @@
// Shared types and constants of the lowest-free identifier allocator.
package lfid_pkg;

  localparam int ID_W        = 16;
  localparam int WORD_W      = 64;
  localparam int CHUNK_W     = 8;
  localparam int DEF_NUM_IDS = 4096;

  localparam logic [ID_W-1:0] DEF_ID_BASE = 16'd300;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NONE  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic            action;
    logic [ID_W-1:0] id_value;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] granted_id;
    logic [1:0]      status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_SUM,
    S_READ,
    S_SCAN_WORD,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/lowest_free_id_allocator.sv @@
// Top level: request sequencer, word summary flags and result register.
//
// Requests arrive on req (req_valid/req_ready). An allocate takes the lowest
// free entry i, marks it used and returns id_base + i (modulo 2^16), or status
// none-free when the map is full. A release clears the entry of id_value, or
// returns status out-of-range when id_value - id_base is not below NUM_IDS.
// Each request yields exactly one result on rsp (rsp_valid/rsp_ready).
// id_base is written through cfg_valid/cfg_data; cfg_ready is always high.
//
// The map is kept in 64-bit words with one summary flag per word that marks
// it full. The sequencer feeds one 8-bit lowest-clear finder, first with
// summary flags (8 words a cycle) and then with the selected word (8 bits
// a cycle). An allocate scans the summary flags, reads the word, scans it,
// writes it back and hands over the result, or goes straight to hand-over
// when the map is full; a release reads and writes the word, and an
// out-of-range release goes straight to hand-over. One request is handled
// at a time; a new one is taken while the previous result still waits in
// the output register, but a result waits for a stalled receiver before
// the following one can be handed over. After reset a clearing pass writes
// zero to every word, with req_ready low.
module lowest_free_id_allocator #(
  parameter int NUM_IDS = lfid_pkg::DEF_NUM_IDS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lfid_pkg::ID_W-1:0] cfg_data,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  lfid_pkg::req_t            req,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output lfid_pkg::rsp_t            rsp
);
  import lfid_pkg::*;

  localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = NUM_WORDS > 1 ? $clog2(NUM_WORDS) : 1;
  localparam int NSC       = (NUM_WORDS + CHUNK_W - 1) / CHUNK_W;
  localparam int SC_W      = NSC > 1 ? $clog2(NSC) : 1;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int CK_W      = $clog2(CHUNK_W);
  localparam int BC_W      = $clog2(WORD_W / CHUNK_W);
  localparam int IDX_W     = WA_W + BIT_W;
  localparam int LAST_BITS = NUM_IDS - (NUM_WORDS - 1) * WORD_W;

  // Bits of the last word that lie beyond NUM_IDS count as used.
  localparam logic [WORD_W-1:0] LAST_PAD = {WORD_W{1'b1}} << LAST_BITS;

  state_t state, state_next;

  logic                   action_q;
  logic [BIT_W-1:0]       bit_pos;
  logic [WA_W-1:0]        word_addr;
  logic [SC_W-1:0]        sum_chunk;
  logic [BC_W-1:0]        bit_chunk;
  logic [ID_W-1:0]        res_id;
  logic [1:0]             res_status;
  logic [ID_W-1:0]        id_base;
  logic [NUM_WORDS-1:0]   full_q;

  logic [NSC*CHUNK_W-1:0] full_pad;
  logic [WORD_W-1:0]      word_pad;
  logic [WORD_W-1:0]      eff_word;
  logic [WORD_W-1:0]      bit_mask;
  logic [WORD_W-1:0]      rd_data;
  logic [WORD_W-1:0]      wr_data;
  logic [CHUNK_W-1:0]     find_in;
  logic                   find_ok;
  logic [CK_W-1:0]        find_pos;
  logic                   rd_en;
  logic                   wr_en;
  logic [ID_W-1:0]        req_off;
  logic                   off_ok;
  logic [IDX_W-1:0]       grant_idx;
  logic                   last_word;
  logic                   last_chunk;
  logic                   load;

  assign cfg_ready  = 1'b1;
  assign req_off    = req.id_value - id_base;
  assign off_ok     = {1'b0, req_off} < (ID_W + 1)'(NUM_IDS);
  assign last_word  = word_addr == WA_W'(NUM_WORDS - 1);
  assign last_chunk = sum_chunk == SC_W'(NSC - 1);
  assign word_pad   = last_word ? LAST_PAD : '0;
  assign eff_word   = rd_data | word_pad;
  assign bit_mask   = WORD_W'(1) << bit_pos;
  assign grant_idx  = {word_addr, bit_pos};
  assign load       = (state == S_DONE) && (!rsp_valid || rsp_ready);

  always_comb begin
    full_pad                = '1;
    full_pad[NUM_WORDS-1:0] = full_q;
  end

  lfid_find8 u_find (
    .used  (find_in),
    .found (find_ok),
    .pos   (find_pos)
  );

  lfid_map #(
    .NUM_WORDS (NUM_WORDS),
    .WA_W      (WA_W)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (word_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (word_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (last_word) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          if (req.action == ACT_ALLOC) state_next = S_SCAN_SUM;
          else if (off_ok)             state_next = S_READ;
          else                         state_next = S_DONE;
        end
      end
      S_SCAN_SUM: begin
        if (find_ok)         state_next = S_READ;
        else if (last_chunk) state_next = S_DONE;
      end
      S_READ: begin
        state_next = (action_q == ACT_ALLOC) ? S_SCAN_WORD : S_WRITE;
      end
      S_SCAN_WORD: begin
        if (find_ok) state_next = S_WRITE;
      end
      S_WRITE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    wr_data   = '0;
    find_in   = eff_word[bit_chunk*CHUNK_W +: CHUNK_W];
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_IDLE: begin
        req_ready = 1'b1;
      end
      S_SCAN_SUM: begin
        find_in = full_pad[sum_chunk*CHUNK_W +: CHUNK_W];
      end
      S_READ: begin
        rd_en = 1'b1;
      end
      S_WRITE: begin
        wr_en   = 1'b1;
        wr_data = (action_q == ACT_ALLOC) ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      word_addr <= '0;
      full_q    <= '0;
      id_base   <= DEF_ID_BASE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        id_base <= cfg_data;
      end
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (!last_word) word_addr <= word_addr + 1'b1;
        end
        S_IDLE: begin
          if (req_valid) begin
            word_addr <= WA_W'(req_off >> BIT_W);
          end
        end
        S_SCAN_SUM: begin
          if (find_ok) word_addr <= WA_W'({sum_chunk, find_pos});
        end
        S_WRITE: begin
          // A release always leaves a clear bit behind, so the word is no longer full.
          full_q[word_addr] <= (action_q == ACT_ALLOC) ? &(wr_data | word_pad) : 1'b0;
        end
        default: begin
          full_q <= full_q;
        end
      endcase
    end
  end

  // Payload registers of the sequencer and the result register.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          action_q   <= req.action;
          sum_chunk  <= '0;
          bit_chunk  <= '0;
          bit_pos    <= req_off[BIT_W-1:0];
          res_id     <= '0;
          res_status <= (req.action == ACT_RELEASE && !off_ok) ? ST_RANGE : ST_OK;
        end
      end
      S_SCAN_SUM: begin
        if (!find_ok) begin
          if (last_chunk) res_status <= ST_NONE;
          else            sum_chunk  <= sum_chunk + 1'b1;
        end
      end
      S_SCAN_WORD: begin
        if (find_ok) bit_pos   <= BIT_W'({bit_chunk, find_pos});
        else         bit_chunk <= bit_chunk + 1'b1;
      end
      S_WRITE: begin
        if (action_q == ACT_ALLOC) res_id <= id_base + ID_W'(grant_idx);
      end
      S_DONE: begin
        if (load) begin
          rsp.granted_id <= res_id;
          rsp.status     <= res_status;
        end
      end
      default: begin
        res_id <= res_id;
      end
    endcase
  end

  a_alloc_bit_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && action_q == ACT_ALLOC) |-> !rd_data[bit_pos])
    else $error("allocate marks an entry that is already in use");

  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && action_q == ACT_ALLOC) |->
      ({1'b0, grant_idx} < (IDX_W + 1)'(NUM_IDS)))
    else $error("allocate picked an entry beyond the map");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("result presented outside the hand-over state");

  a_release_not_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && action_q == ACT_RELEASE) |=> !full_q[$past(word_addr)])
    else $error("summary flag still marks a word full after a release");

endmodule

@@ hw/rtl/lfid_find8.sv @@
// Shared search unit: position of the lowest clear bit in an 8-bit slice.
module lfid_find8 (
  input  logic [lfid_pkg::CHUNK_W-1:0]         used,
  output logic                                 found,
  output logic [$clog2(lfid_pkg::CHUNK_W)-1:0] pos
);
  import lfid_pkg::*;

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        pos   = ($clog2(CHUNK_W))'(i);
      end
    end
  end

endmodule

@@ hw/rtl/lfid_map.sv @@
// Bitmap storage: one write port, one registered read port, one word per address.
module lfid_map #(
  parameter int NUM_WORDS = 64,
  parameter int WA_W      = 6
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [WA_W-1:0]             wr_addr,
  input  logic [lfid_pkg::WORD_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [WA_W-1:0]             rd_addr,
  output logic [lfid_pkg::WORD_W-1:0] rd_data
);
  import lfid_pkg::*;

  logic [WORD_W-1:0] mem [NUM_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
